// ===== hdl/wfa_pkg.sv =====
// Shared types, codes, constants and small tables of the window multiplier.
`timescale 1ns / 1ps

package wfa_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 1;
    localparam int MAX_FRAME      = 4096;
    localparam int IDX_W          = 12;
    localparam int FLEN_W         = 13;
    localparam int MODE_W         = 2;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int DIV_STEPS      = 32;
    localparam int CNT_W          = $clog2(DIV_STEPS);
    localparam int OP_W           = 4;
    localparam int TIDX_W         = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_MODE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LENGTH = 1'b1;

    // window modes
    localparam logic [MODE_W-1:0] MODE_RECT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HANN     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HAMMING  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BLACKMAN = 2'd3;

    // Q30 constants
    localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [31:0] Q30_PIO2 = 32'd1686629713;
    localparam logic [31:0] Q30_HALF = 32'd536870912;
    localparam logic [31:0] Q30_C054 = 32'd579820585;
    localparam logic [31:0] Q30_C046 = 32'd493921239;
    localparam logic [31:0] Q30_C042 = 32'd450971566;
    localparam logic [31:0] Q30_C008 = 32'd85899346;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd2;
    localparam logic [OP_W-1:0] OP_X    = 4'd3;
    localparam logic [OP_W-1:0] OP_Y    = 4'd4;
    localparam logic [OP_W-1:0] OP_YL   = 4'd5;
    localparam logic [OP_W-1:0] OP_P    = 4'd6;
    localparam logic [OP_W-1:0] OP_Q    = 4'd7;
    localparam logic [OP_W-1:0] OP_C    = 4'd8;
    localparam logic [OP_W-1:0] OP_E    = 4'd9;
    localparam logic [OP_W-1:0] OP_K    = 4'd10;
    localparam logic [OP_W-1:0] OP_W_   = 4'd11;
    localparam logic [OP_W-1:0] OP_CF   = 4'd12;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd13;

    // Horner terms 0..4 divide, term 5 is the closing halving
    localparam logic [TIDX_W-1:0] TERM_LAST = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIDX_W-1:0] term_idx;
        logic              second;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic blackman;
        logic out_free;
    } stat_t;

    function automatic logic [7:0] term_div(input logic [TIDX_W-1:0] i);
        logic [7:0] d;
        unique case (i)
            3'd0:    d = 8'd132;
            3'd1:    d = 8'd90;
            3'd2:    d = 8'd56;
            3'd3:    d = 8'd30;
            default: d = 8'd12;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [28:0] term_recip(input logic [TIDX_W-1:0] i);
        logic [28:0] m;
        unique case (i)
            3'd0:    m = 29'd32537631;
            3'd1:    m = 29'd47721858;
            3'd2:    m = 29'd76695844;
            3'd3:    m = 29'd143165576;
            default: m = 29'd357913941;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/window_function_apply_core.sv =====
// Window multiplier top level: sequencer plus datapath.
//
// Multiplies each complex sample of a frame by a rectangular, Hann, Hamming
// or Blackman coefficient for its position n in a frame of frame_length
// samples. Samples enter on the s_ channel (valid/ready), results leave on
// the m_ channel with m_last_of_frame set on the last sample of a frame.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while idle, which the block itself does not enforce.
// One sample is worked on at a time. Per sample: a load step, the bit-serial
// divider for n/(N-1), each cosine on the shared 32x32 multiplier, a scale
// and accumulate step per cosine, a clamp and round step, an output step.
// Rectangular and one-sample frames go from the load straight to the output
// step; Hann/Hamming take one cosine, Blackman two. s_ready rises again in
// the same cycle as m_valid.
// The result sits in an output register; a stalled receiver only holds the
// sequencer in its output step once the next result is ready.
// Reset: mode rectangular, frame length 4096, position 0, no result valid,
// s_ready low while aresetn is low.
`timescale 1ns / 1ps

module window_function_apply_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [wfa_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0] s_sample_re,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0] s_sample_im,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0] m_out_re,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0] m_out_im,
    output logic                                   m_last_of_frame
);

    wfa_pkg::cmd_t  cmd;
    wfa_pkg::stat_t stat;

    wfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wfa_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_sample_re     (s_sample_re),
        .s_sample_im     (s_sample_im),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_re        (m_out_re),
        .m_out_im        (m_out_im),
        .m_last_of_frame (m_last_of_frame),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

// ===== hdl/wfa_ctrl.sv =====
// Sequencer of the window multiplier: steps the datapath through one sample.
`timescale 1ns / 1ps

module wfa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wfa_pkg::stat_t stat,
    output wfa_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_X    = 4'd2;
    localparam logic [3:0] ST_Y    = 4'd3;
    localparam logic [3:0] ST_YL   = 4'd4;
    localparam logic [3:0] ST_P    = 4'd5;
    localparam logic [3:0] ST_Q    = 4'd6;
    localparam logic [3:0] ST_C    = 4'd7;
    localparam logic [3:0] ST_E    = 4'd8;
    localparam logic [3:0] ST_K    = 4'd9;
    localparam logic [3:0] ST_W    = 4'd10;
    localparam logic [3:0] ST_CF   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0]                  state_reg, state_next;
    logic [wfa_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [wfa_pkg::TIDX_W-1:0]  idx_reg, idx_next;
    logic                        second_reg, second_next;

    // no transfer is taken while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        second_next  = second_reg;
        cmd.op       = wfa_pkg::OP_NONE;
        cmd.term_idx = idx_reg;
        cmd.second   = second_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op      = wfa_pkg::OP_LOAD;
                    second_next = 1'b0;
                    cnt_next    = '0;
                    state_next  = stat.bypass ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op   = wfa_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wfa_pkg::CNT_W'(wfa_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_X;
                end
            end
            ST_X: begin
                cmd.op     = wfa_pkg::OP_X;
                state_next = ST_Y;
            end
            ST_Y: begin
                cmd.op     = wfa_pkg::OP_Y;
                state_next = ST_YL;
            end
            ST_YL: begin
                cmd.op     = wfa_pkg::OP_YL;
                idx_next   = '0;
                state_next = ST_P;
            end
            ST_P: begin
                cmd.op     = wfa_pkg::OP_P;
                state_next = (idx_reg == wfa_pkg::TERM_LAST) ? ST_E : ST_Q;
            end
            ST_Q: begin
                cmd.op     = wfa_pkg::OP_Q;
                state_next = ST_C;
            end
            ST_C: begin
                cmd.op     = wfa_pkg::OP_C;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_P;
            end
            ST_E: begin
                cmd.op     = wfa_pkg::OP_E;
                state_next = ST_K;
            end
            ST_K: begin
                cmd.op     = wfa_pkg::OP_K;
                state_next = ST_W;
            end
            ST_W: begin
                cmd.op = wfa_pkg::OP_W_;
                // Blackman needs a second cosine at twice the phase
                if (stat.blackman && !second_reg) begin
                    second_next = 1'b1;
                    state_next  = ST_X;
                end else begin
                    state_next  = ST_CF;
                end
            end
            ST_CF: begin
                cmd.op     = wfa_pkg::OP_CF;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = wfa_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            second_reg <= second_next;
        end
    end

endmodule

// ===== hdl/wfa_datapath.sv =====
// Datapath of the window multiplier: registers, phase divider, shared multiplier.
`timescale 1ns / 1ps

module wfa_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [wfa_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0] s_sample_re,
    input  logic signed [wfa_pkg::SAMPLE_BITS-1:0] s_sample_im,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0] m_out_re,
    output logic signed [wfa_pkg::SAMPLE_BITS-1:0] m_out_im,
    output logic                                 m_last_of_frame,
    input  wfa_pkg::cmd_t                        cmd,
    output wfa_pkg::stat_t                       stat
);

    localparam int SB       = wfa_pkg::SAMPLE_BITS;
    localparam int CFB      = wfa_pkg::COEF_FRAC_BITS;
    localparam int CW       = wfa_pkg::COEF_W;
    localparam int IW       = wfa_pkg::IDX_W;
    localparam int FW       = wfa_pkg::FLEN_W;
    localparam int SP_W     = SB + CW + 1;
    localparam int CSHIFT   = 30 - CFB;

    // configuration and frame position
    logic [wfa_pkg::MODE_W-1:0] mode_reg;
    logic [FW-1:0]              flen_reg;
    logic [IW-1:0]              index_reg;
    logic                       mvalid_reg;

    // payload
    logic signed [SB-1:0] re_reg, im_reg;
    logic                 last_reg;
    logic [IW-1:0]        div_reg, rem_reg;
    logic [31:0]          ph_reg;
    logic                 neg_reg;
    logic [63:0]          prod_reg;
    logic [31:0]          y_reg, p_reg;
    logic [30:0]          term_reg;
    logic [30:0]          cmag_reg;
    logic                 csgn_reg;
    logic signed [32:0]   acc_reg;
    logic [CW-1:0]        coef_reg;
    logic signed [SB-1:0] out_re_reg, out_im_reg;
    logic                 out_last_reg;

    logic [FW-1:0]        nlen;
    logic [FW-1:0]        nlen_m1;
    logic [IW-1:0]        d_cur;
    logic                 last_cur;
    logic [IW:0]          rem2;
    logic                 rem_ge;
    logic [IW:0]          rem_sub;
    logic [31:0]          t_sel;
    logic [30:0]          u_val;
    logic [31:0]          mul_a, mul_b, k_sel;
    logic [63:0]          mul_p;
    logic [28:0]          q0;
    logic [7:0]           dv;
    logic [36:0]          qd, rr;
    logic [29:0]          qfix;
    logic [31:0]          p_e;
    logic signed [32:0]   c_e, cv_e, cabs_e;
    logic [63:0]          wsum;
    logic signed [32:0]   mt;
    logic [31:0]          base_sel;
    logic [30:0]          w_cl, w_rnd;

    function automatic logic signed [SB-1:0] scale(input logic signed [SB-1:0] s,
                                                   input logic [CW-1:0] c);
        logic signed [SP_W-1:0] pr;
        logic signed [SP_W-1:0] rn;
        logic signed [SP_W-CFB-1:0] sh;
        logic signed [SB-1:0] r;
        pr = $signed({{(SP_W-SB){s[SB-1]}}, s}) * $signed({{(SP_W-CW){1'b0}}, c});
        rn = pr + $signed(SP_W'(1) <<< (CFB - 1));
        sh = rn[SP_W-1:CFB];
        if (sh > $signed((SP_W-CFB)'((1 << (SB - 1)) - 1))) begin
            r = {1'b0, {(SB-1){1'b1}}};
        end else if (sh < -$signed((SP_W-CFB)'(1 << (SB - 1)))) begin
            r = {1'b1, {(SB-1){1'b0}}};
        end else begin
            r = sh[SB-1:0];
        end
        return r;
    endfunction

    // effective frame length and position
    always_comb begin
        if (flen_reg == '0) begin
            nlen = FW'(1);
        end else if (flen_reg > FW'(wfa_pkg::MAX_FRAME)) begin
            nlen = FW'(wfa_pkg::MAX_FRAME);
        end else begin
            nlen = flen_reg;
        end
        nlen_m1  = nlen - FW'(1);
        d_cur    = nlen_m1[IW-1:0];
        last_cur = (index_reg >= d_cur);
    end

    assign stat.bypass   = (mode_reg == wfa_pkg::MODE_RECT) || (nlen == FW'(1));
    assign stat.blackman = (mode_reg == wfa_pkg::MODE_BLACKMAN);
    assign stat.out_free = !mvalid_reg || m_ready;

    // one fraction bit of n/(N-1) per step
    assign rem2    = {rem_reg, 1'b0};
    assign rem_ge  = (rem2 >= {1'b0, div_reg});
    assign rem_sub = rem2 - {1'b0, div_reg};

    // fold the turn into a quarter wave
    assign t_sel = cmd.second ? {ph_reg[30:0], 1'b0} : ph_reg;
    assign u_val = t_sel[30] ? (wfa_pkg::Q30_ONE[30:0] - {1'b0, t_sel[29:0]})
                             : {1'b0, t_sel[29:0]};

    always_comb begin
        if (cmd.second) begin
            k_sel = wfa_pkg::Q30_C008;
        end else if (mode_reg == wfa_pkg::MODE_HAMMING) begin
            k_sel = wfa_pkg::Q30_C046;
        end else begin
            k_sel = wfa_pkg::Q30_HALF;
        end
        unique case (mode_reg)
            wfa_pkg::MODE_HAMMING:  base_sel = wfa_pkg::Q30_C054;
            wfa_pkg::MODE_BLACKMAN: base_sel = wfa_pkg::Q30_C042;
            default:                base_sel = wfa_pkg::Q30_HALF;
        endcase
    end

    // shared multiplier
    always_comb begin
        unique case (cmd.op)
            wfa_pkg::OP_X: begin
                mul_a = {1'b0, u_val};
                mul_b = wfa_pkg::Q30_PIO2;
            end
            wfa_pkg::OP_Y: begin
                mul_a = {1'b0, prod_reg[60:30]};
                mul_b = {1'b0, prod_reg[60:30]};
            end
            wfa_pkg::OP_P: begin
                mul_a = y_reg;
                mul_b = {1'b0, term_reg};
            end
            wfa_pkg::OP_Q: begin
                mul_a = prod_reg[61:30];
                mul_b = {3'b000, wfa_pkg::term_recip(cmd.term_idx)};
            end
            wfa_pkg::OP_K: begin
                mul_a = {1'b0, cmag_reg};
                mul_b = k_sel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // reciprocal quotient is low by at most one
    assign q0   = prod_reg[60:32];
    assign dv   = wfa_pkg::term_div(cmd.term_idx);
    assign qd   = {8'd0, q0} * {29'd0, dv};
    assign rr   = {5'd0, p_reg} - qd;
    assign qfix = {1'b0, q0} + {29'd0, (rr >= {29'd0, dv})};

    // closing Horner step and quadrant sign
    always_comb begin
        p_e    = prod_reg[61:30];
        c_e    = $signed({1'b0, wfa_pkg::Q30_ONE}) - $signed({2'b00, p_e[31:1]});
        cv_e   = neg_reg ? -c_e : c_e;
        cabs_e = cv_e[32] ? -cv_e : cv_e;
    end

    // constant times cosine, rounded half away from zero
    assign wsum = prod_reg + (64'd1 << 29);
    assign mt   = csgn_reg ? -$signed({1'b0, wsum[61:30]}) : $signed({1'b0, wsum[61:30]});

    always_comb begin
        if (acc_reg < 0) begin
            w_cl = '0;
        end else if (acc_reg > $signed({1'b0, wfa_pkg::Q30_ONE})) begin
            w_cl = wfa_pkg::Q30_ONE[30:0];
        end else begin
            w_cl = acc_reg[30:0];
        end
        w_rnd = w_cl + (31'd1 << (CSHIFT - 1));
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= wfa_pkg::MODE_RECT;
            flen_reg   <= FW'(wfa_pkg::MAX_FRAME);
            index_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    wfa_pkg::CFG_WINDOW_MODE:  mode_reg <= cfg_wdata[wfa_pkg::MODE_W-1:0];
                    default:                   flen_reg <= cfg_wdata[FW-1:0];
                endcase
            end
            if (cmd.op == wfa_pkg::OP_LOAD) begin
                index_reg <= last_cur ? '0 : index_reg + 1'b1;
            end
            if (cmd.op == wfa_pkg::OP_OUT) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            wfa_pkg::OP_LOAD: begin
                re_reg   <= s_sample_re;
                im_reg   <= s_sample_im;
                last_reg <= last_cur;
                div_reg  <= d_cur;
                rem_reg  <= last_cur ? '0 : index_reg;
                coef_reg <= CW'(1) << CFB;
            end
            wfa_pkg::OP_DIV: begin
                rem_reg <= rem_ge ? rem_sub[IW-1:0] : rem2[IW-1:0];
                ph_reg  <= {ph_reg[30:0], rem_ge};
            end
            wfa_pkg::OP_X: begin
                prod_reg <= mul_p;
                neg_reg  <= t_sel[31] ^ t_sel[30];
            end
            wfa_pkg::OP_Y, wfa_pkg::OP_P, wfa_pkg::OP_K: begin
                prod_reg <= mul_p;
            end
            wfa_pkg::OP_YL: begin
                y_reg    <= prod_reg[61:30];
                term_reg <= wfa_pkg::Q30_ONE[30:0];
            end
            wfa_pkg::OP_Q: begin
                p_reg    <= prod_reg[61:30];
                prod_reg <= mul_p;
            end
            wfa_pkg::OP_C: begin
                term_reg <= wfa_pkg::Q30_ONE[30:0] - {1'b0, qfix};
            end
            wfa_pkg::OP_E: begin
                csgn_reg <= cv_e[32];
                cmag_reg <= cabs_e[30:0];
            end
            wfa_pkg::OP_W_: begin
                acc_reg <= cmd.second ? (acc_reg + mt)
                                      : ($signed({1'b0, base_sel}) - mt);
            end
            wfa_pkg::OP_CF: begin
                coef_reg <= w_rnd[30:CSHIFT];
            end
            wfa_pkg::OP_OUT: begin
                out_re_reg   <= scale(re_reg, coef_reg);
                out_im_reg   <= scale(im_reg, coef_reg);
                out_last_reg <= last_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = mvalid_reg;
    assign m_out_re        = out_re_reg;
    assign m_out_im        = out_im_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the frame window multiplier core.
`timescale 1ns / 1ps

module tb;
    import wfa_pkg::*;

    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int SAMPLE_TARGET = 850;

    // receiver stall styles
    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_RARE   = 3;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          last;
    } win_result_t;

    class window_tracker;
        logic [MODE_W-1:0] mode;
        logic [FLEN_W-1:0] flen;
        int unsigned       position;
        win_result_t       pending[$];
        int                errors;

        function new();
            mode     = MODE_RECT;
            flen     = FLEN_W'(MAX_FRAME);
            position = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == CFG_WINDOW_MODE) begin
                mode = data[MODE_W-1:0];
            end else if (addr == CFG_FRAME_LENGTH) begin
                flen = data[FLEN_W-1:0];
            end
        endfunction

        // Taylor series of cos over a quarter turn, Q30 in and out
        function longint cos_quarter(longint unsigned u);
            longint unsigned x, y, term, d;
            x = (u * 64'(Q30_PIO2)) >> 30;
            y = (x * x) >> 30;
            term = UNIT_Q30;
            for (int i = 0; i < 5; i++) begin
                case (i)
                    0:       d = 132;
                    1:       d = 90;
                    2:       d = 56;
                    3:       d = 30;
                    default: d = 12;
                endcase
                term = UNIT_Q30 - ((y * term) >> 30) / d;
            end
            return longint'(UNIT_Q30) - longint'(((y * term) >> 30) / 2);
        endfunction

        function longint cos_turn(logic [31:0] t);
            longint unsigned r;
            r = 64'(t[29:0]);
            case (t[31:30])
                2'd0:    return cos_quarter(r);
                2'd1:    return -cos_quarter(UNIT_Q30 - r);
                2'd2:    return -cos_quarter(r);
                default: return cos_quarter(UNIT_Q30 - r);
            endcase
        endfunction

        // constant times cosine, rounded half away from zero
        function longint scale_const(longint c, longint unsigned k);
            longint unsigned m, p;
            if (c < 0) m = -c;
            else m = c;
            p = (m * k + (64'd1 << 29)) >> 30;
            return (c < 0) ? -longint'(p) : longint'(p);
        endfunction

        function logic [COEF_W-1:0] window_coef(int unsigned n, int unsigned nlen);
            longint unsigned ph;
            logic [31:0]     t1, t2;
            longint          c1, w;
            if (mode == MODE_RECT || nlen <= 1) return COEF_W'(1) << COEF_FRAC_BITS;
            ph = (64'(n) << 32) / 64'(nlen - 1);
            t1 = ph[31:0];
            t2 = {ph[30:0], 1'b0};
            c1 = cos_turn(t1);
            case (mode)
                MODE_HANN:    w = longint'(Q30_HALF) - scale_const(c1, Q30_HALF);
                MODE_HAMMING: w = longint'(Q30_C054) - scale_const(c1, Q30_C046);
                default:      w = longint'(Q30_C042) - scale_const(c1, Q30_HALF)
                                  + scale_const(cos_turn(t2), Q30_C008);
            endcase
            // rounding can push the coefficient slightly below zero
            if (w < 0) w = 0;
            if (w > longint'(UNIT_Q30)) w = longint'(UNIT_Q30);
            w = (w + (64'sd1 << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
            return w[COEF_W-1:0];
        endfunction

        function logic signed [SAMPLE_BITS-1:0] apply_coef(logic signed [SAMPLE_BITS-1:0] s,
                                                            logic [COEF_W-1:0] coef);
            longint p;
            p = longint'(s) * longint'(coef) + (64'sd1 <<< (COEF_FRAC_BITS - 1));
            p = p >>> COEF_FRAC_BITS;
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            return p[SAMPLE_BITS-1:0];
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] re,
                                  logic signed [SAMPLE_BITS-1:0] im);
            int unsigned       nlen, n;
            logic              last;
            logic [COEF_W-1:0] coef;
            win_result_t       r;
            nlen = flen;
            if (nlen == 0) nlen = 1;
            if (nlen > MAX_FRAME) nlen = MAX_FRAME;
            n = position;
            // a position past the frame end counts as the last sample
            last = (n >= nlen - 1);
            if (last) n = nlen - 1;
            coef = window_coef(n, nlen);
            r.re = apply_coef(re, coef);
            r.im = apply_coef(im, coef);
            r.last = last;
            pending.push_back(r);
            position = last ? 0 : n + 1;
        endfunction

        function void check_result(logic signed [SAMPLE_BITS-1:0] re,
                                   logic signed [SAMPLE_BITS-1:0] im, logic last);
            win_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result: out_re %0d out_im %0d last_of_frame %0b",
                       re, im, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (re !== want.re) begin
                $error("out_re mismatch: expected %0d, got %0d", want.re, re);
                errors++;
            end
            if (im !== want.im) begin
                $error("out_im mismatch: expected %0d, got %0d", want.im, im);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_frame mismatch: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [CFG_ADDR_W-1:0]         cfg_addr;
    logic [CFG_DATA_W-1:0]         cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_re;
    logic signed [SAMPLE_BITS-1:0] s_sample_im;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_out_re;
    logic signed [SAMPLE_BITS-1:0] m_out_im;
    logic                          m_last_of_frame;

    window_tracker board;
    int            samples_sent;

    window_function_apply_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_re     (s_sample_re),
        .s_sample_im     (s_sample_im),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_re        (m_out_re),
        .m_out_im        (m_out_im),
        .m_last_of_frame (m_last_of_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // all driving tasks start and end just after a falling edge
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im);
        s_valid     <= 1'b1;
        s_sample_re <= re;
        s_sample_im <= im;
        do @(posedge aclk); while (!s_ready);
        board.note_sample(re, im);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        board.write_reg(addr, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // hold the sender off until every pending result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh ffff;
            3:       return SAMPLE_BITS'($urandom_range(0, 3));
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic stream_samples(input int count, input bit gaps);
        int burst;
        burst = $urandom_range(1, 24);
        for (int i = 0; i < count; i++) begin
            push_sample(rand_sample(), rand_sample());
            burst--;
            if (gaps && burst == 0) begin
                pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                         : $urandom_range(1, 30));
                burst = $urandom_range(1, 24);
            end
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_frame_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return CFG_DATA_W'($urandom_range(2, 16));
        if (r < 80) return CFG_DATA_W'($urandom_range(17, 64));
        if (r < 88) return CFG_DATA_W'($urandom_range(65, 400));
        if (r < 92) return CFG_DATA_W'($urandom_range(0, 1));
        if (r < 96) return CFG_DATA_W'(MAX_FRAME);
        return CFG_DATA_W'($urandom_range(MAX_FRAME + 1, (1 << FLEN_W) - 1));
    endfunction

    // receiver: stall style changes every so often
    initial begin
        int style, span, tick;
        m_ready = 1'b0;
        tick = 0;
        forever begin
            style = $urandom_range(RX_ALWAYS, RX_RARE);
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                case (style)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= (tick % 7 == 0);
                    default:   m_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_out_re, m_out_im, m_last_of_frame);
        end
    end

    // watchdog: cycles without any transfer on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("window_function_apply_core test failed");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] flen_word;
        int                    flen_eff, count;
        board        = new();
        samples_sent = 0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_sample_re  = '0;
        s_sample_im  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // rectangular pass-through at reset settings, field extremes
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh8000, 16'sh7fff);
        push_sample(16'sh0000, 16'shffff);
        push_sample(16'sh5555, 16'shaaaa);
        push_sample(16'shaaaa, 16'sh5555);
        drain_results();

        // single-sample frame; position is past the end here
        write_reg(CFG_WINDOW_MODE, CFG_DATA_W'(MODE_HANN));
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(1));
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh8000, 16'sh1234);
        drain_results();

        // zero length behaves as one
        write_reg(CFG_WINDOW_MODE, CFG_DATA_W'(MODE_BLACKMAN));
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(0));
        push_sample(16'sh7fff, 16'sh7fff);
        push_sample(16'sh8000, 16'sh8000);
        drain_results();

        // Blackman ends go through the clamp at zero
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(5));
        for (int i = 0; i < 5; i++) push_sample(16'sh7fff, 16'sh8000);
        drain_results();

        write_reg(CFG_WINDOW_MODE, CFG_DATA_W'(MODE_HAMMING));
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(3));
        for (int i = 0; i < 3; i++) push_sample(16'sh8000, 16'sh7fff);
        drain_results();

        write_reg(CFG_WINDOW_MODE, CFG_DATA_W'(MODE_HANN));
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(2));
        push_sample(16'sh7fff, 16'sh8000);
        push_sample(16'sh7fff, 16'sh8000);
        drain_results();

        // oversize length saturates, then shrink the frame mid-way
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'((1 << FLEN_W) - 1));
        for (int i = 0; i < 3; i++) push_sample(16'sh4000, 16'shc000);
        drain_results();
        write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(2));
        push_sample(16'sh7fff, 16'sh8000);
        drain_results();

        flen_eff = 2;
        while (samples_sent < SAMPLE_TARGET) begin
            drain_results();
            // upper data bits of a mode write are don't-care
            if ($urandom_range(0, 3) != 0) begin
                write_reg(CFG_WINDOW_MODE,
                          {(CFG_DATA_W - MODE_W)'($urandom()), MODE_W'($urandom_range(0, 3))});
            end
            if ($urandom_range(0, 4) != 0) begin
                flen_word = pick_frame_length();
                write_reg(CFG_FRAME_LENGTH, flen_word);
                flen_eff = (flen_word == 0) ? 1 : flen_word;
                if (flen_eff > MAX_FRAME) flen_eff = MAX_FRAME;
            end
            if (flen_eff <= 40) begin
                count = flen_eff * $urandom_range(1, 3) + $urandom_range(0, 1);
            end else begin
                count = $urandom_range(20, (flen_eff <= 400) ? flen_eff : 150);
            end
            stream_samples(count, $urandom_range(0, 3) != 0);
        end

        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("window_function_apply_core test passed");
        end else begin
            $display("window_function_apply_core test failed");
        end
        $finish;
    end

endmodule
